// ===== hdl/gld_pkg.sv =====
// Package for the grid longest descending path block: shared constants.
`default_nettype none
package gld_pkg;
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_MAX_COLS    = 64;
    localparam int DEF_HEIGHT_BITS = 16;
    localparam int IN_HEIGHT_BITS  = 16;
    localparam int LONGEST_BITS    = 13;
    localparam int CFG_REG_BITS    = 7;
    localparam int CFG_IDX_BITS    = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROWS = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COLS = 1'b1;
endpackage
`default_nettype wire

// ===== hdl/gld_mem.sv =====
// Height and length memories, one write and one shared registered read port each.
`default_nettype none
module gld_mem #(
    parameter int CELLS = 4096,
    parameter int AW    = 12,
    parameter int HB    = 16,
    parameter int LW    = 13
) (
    input  wire logic          i_clk,
    input  wire logic          i_hw_en,
    input  wire logic [AW-1:0] i_hw_addr,
    input  wire logic [HB-1:0] i_hw_data,
    input  wire logic          i_lw_en,
    input  wire logic [AW-1:0] i_lw_addr,
    input  wire logic [LW-1:0] i_lw_data,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [HB-1:0] o_h_q,
    output logic      [LW-1:0] o_l_q
);
    logic [HB-1:0] r_hmem [CELLS];
    logic [LW-1:0] r_lmem [CELLS];

    always_ff @(posedge i_clk) begin
        if (i_hw_en) begin
            r_hmem[i_hw_addr] <= i_hw_data;
        end
        o_h_q <= r_hmem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_lw_en) begin
            r_lmem[i_lw_addr] <= i_lw_data;
        end
        o_l_q <= r_lmem[i_rd_addr];
    end
endmodule
`default_nettype wire

// ===== hdl/grid_longest_descent_path.sv =====
// Top level: grid load, length relaxation sweeps and result register.
//
//  channel | direction | handshake              | payload
//  input   | in        | i_valid / o_ready      | i_height, i_last
//  result  | out       | o_valid / i_ready      | o_longest
//  config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_value
//
// Loading takes one height per cycle into the height memory.
// After last: an init pass over all rows*cols cells sets every length to 1,
// then relaxation sweeps (one shared memory read port, five reads per cell)
// repeat until a sweep changes nothing.
// Input is not taken from last until the result is registered; a waiting
// result does not stop loading of the next grid. Reset is synchronous.
`default_nettype none
module grid_longest_descent_path #(
    parameter int MAX_ROWS    = gld_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = gld_pkg::DEF_MAX_COLS,
    parameter int HEIGHT_BITS = gld_pkg::DEF_HEIGHT_BITS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [gld_pkg::IN_HEIGHT_BITS-1:0] i_height,
    input  wire logic                               i_last,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic      [gld_pkg::LONGEST_BITS-1:0]   o_longest,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [gld_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [gld_pkg::CFG_REG_BITS-1:0]   i_cfg_value
);
    import gld_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW    = $clog2(CELLS + 1);
    localparam int LW    = $clog2(CELLS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int KW    = $clog2(MAX_COLS + 1);

    typedef enum logic [1:0] {S_LOAD, S_INIT, S_SWEEP, S_DONE} t_state;

    t_state                  r_state;
    logic [CFG_REG_BITS-1:0] r_rows, r_cols;
    logic [CW-1:0]           r_load;
    logic [AW-1:0]           r_idx;
    logic [RW-1:0]           r_row;
    logic [KW-1:0]           r_col;
    logic [2:0]              r_ph;
    logic                    r_nv;
    logic [HEIGHT_BITS-1:0]  r_hself;
    logic [LW-1:0]           r_lself, r_most, r_best;
    logic                    r_changed;
    logic                    r_out_valid;
    logic [LONGEST_BITS-1:0] r_longest;

    logic [RW-1:0]          nr;
    logic [KW-1:0]          nc;
    logic [CW-1:0]          total;
    logic                   in_acc, last_cell, cand, nv, changed_any;
    logic [AW-1:0]          rd_addr;
    logic [HEIGHT_BITS-1:0] h_q;
    logic [LW-1:0]          l_q, most_now, new_len, best_now;

    always_comb begin
        if (r_rows == '0) nr = RW'(1);
        else if (int'(r_rows) > MAX_ROWS) nr = RW'(MAX_ROWS);
        else nr = RW'(r_rows);
        if (r_cols == '0) nc = KW'(1);
        else if (int'(r_cols) > MAX_COLS) nc = KW'(MAX_COLS);
        else nc = KW'(r_cols);
    end

    assign total     = CW'(nr) * CW'(nc);
    assign o_ready   = (r_state == S_LOAD);
    assign in_acc    = i_valid && o_ready;
    assign last_cell = (r_row == nr - RW'(1)) && (r_col == nc - KW'(1));
    assign o_cfg_ready = 1'b1;
    assign o_valid   = r_out_valid;
    assign o_longest = r_longest;

    always_comb begin
        rd_addr = r_idx;
        nv      = 1'b0;
        unique case (r_ph)
            3'd1: begin
                rd_addr = r_idx - AW'(nc);
                nv      = (r_row != '0);
            end
            3'd2: begin
                rd_addr = r_idx + AW'(nc);
                nv      = ((RW+1)'(r_row) + (RW+1)'(1)) < (RW+1)'(nr);
            end
            3'd3: begin
                rd_addr = r_idx - AW'(1);
                nv      = (r_col != '0);
            end
            3'd4: begin
                rd_addr = r_idx + AW'(1);
                nv      = ((KW+1)'(r_col) + (KW+1)'(1)) < (KW+1)'(nc);
            end
            default: begin
                rd_addr = r_idx;
                nv      = 1'b0;
            end
        endcase
    end

    assign cand        = r_nv && (h_q < r_hself) && (l_q > r_most);
    assign most_now    = cand ? l_q : r_most;
    assign new_len     = most_now + LW'(1);
    assign best_now    = (new_len > r_best) ? new_len : r_best;
    assign changed_any = r_changed || (new_len != r_lself);

    gld_mem #(.CELLS(CELLS), .AW(AW), .HB(HEIGHT_BITS), .LW(LW)) u_mem (
        .i_clk     (i_clk),
        .i_hw_en   (in_acc && (r_load < total)),
        .i_hw_addr (r_load[AW-1:0]),
        .i_hw_data (HEIGHT_BITS'(i_height)),
        .i_lw_en   ((r_state == S_INIT) || ((r_state == S_SWEEP) && (r_ph == 3'd5))),
        .i_lw_addr (r_idx),
        .i_lw_data ((r_state == S_INIT) ? LW'(1) : new_len),
        .i_rd_addr (rd_addr),
        .o_h_q     (h_q),
        .o_l_q     (l_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_rows      <= CFG_REG_BITS'(1);
            r_cols      <= CFG_REG_BITS'(1);
            r_load      <= '0;
            r_out_valid <= 1'b0;
            r_ph        <= '0;
            r_idx       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_changed   <= 1'b0;
            r_best      <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_ROWS: r_rows <= i_cfg_value;
                    REG_COLS: r_cols <= i_cfg_value;
                    default:  ;
                endcase
            end
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            r_nv <= nv;
            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (i_last) begin
                            r_load  <= '0;
                            r_state <= S_INIT;
                            r_idx   <= '0;
                            r_row   <= '0;
                            r_col   <= '0;
                        end else if (r_load < total) begin
                            r_load <= r_load + CW'(1);
                        end
                    end
                end
                S_INIT, S_SWEEP: begin
                    if (r_state == S_SWEEP && r_ph != 3'd5) begin
                        r_ph <= r_ph + 3'd1;
                        if (r_ph == 3'd1) begin
                            r_hself <= h_q;
                            r_lself <= l_q;
                            r_most  <= '0;
                        end else if (r_ph != 3'd0) begin
                            r_most <= most_now;
                        end
                    end else begin
                        r_ph <= '0;
                        if (r_state == S_SWEEP && !(last_cell && changed_any)) begin
                            r_changed <= changed_any;
                            r_best    <= best_now;
                        end
                        if (last_cell) begin
                            r_idx <= '0;
                            r_row <= '0;
                            r_col <= '0;
                            if (r_state == S_INIT || changed_any) begin
                                r_state   <= S_SWEEP;
                                r_changed <= 1'b0;
                                r_best    <= '0;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end else begin
                            r_idx <= r_idx + AW'(1);
                            if (r_col == nc - KW'(1)) begin
                                r_col <= '0;
                                r_row <= r_row + RW'(1);
                            end else begin
                                r_col <= r_col + KW'(1);
                            end
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_longest   <= LONGEST_BITS'(r_best);
                        r_state     <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    a_rise_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside done state");
    a_fall_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_out_valid) |-> $past(i_ready))
        else $error("result dropped without transaction");
    a_ready_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> !o_ready)
        else $error("input ready during sweep");
endmodule
`default_nettype wire

// ===== dv/gld_checker.sv =====
// Checker for the grid longest descending path block: predicts and compares results.
module gld_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [gld_pkg::IN_HEIGHT_BITS-1:0]  i_height,
    input  logic                                i_last,
    input  logic                                i_res_valid,
    input  logic                                i_res_ready,
    input  logic [gld_pkg::LONGEST_BITS-1:0]    i_longest,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [gld_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [gld_pkg::CFG_REG_BITS-1:0]    i_cfg_value,
    output int                                  o_fails,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import gld_pkg::*;

    localparam int NCELLS = DEF_MAX_ROWS * DEF_MAX_COLS;

    logic [IN_HEIGHT_BITS-1:0] heights [NCELLS];
    int                        path_len [NCELLS];
    logic [CFG_REG_BITS-1:0]   rows_reg, cols_reg;
    int                        loaded;
    int                        fails;
    logic [LONGEST_BITS-1:0]   longest_q [$];

    function automatic int clamp_size(logic [CFG_REG_BITS-1:0] v, int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // relax lengths upward from 1 until stable
    function automatic logic [LONGEST_BITS-1:0] longest_descent(int nr, int nc);
        int total, i, r, c, m, best;
        bit changed;
        total = nr * nc;
        best = 0;
        for (i = 0; i < total; i++) path_len[i] = 1;
        changed = 1;
        while (changed) begin
            changed = 0;
            for (i = 0; i < total; i++) begin
                r = i / nc;
                c = i % nc;
                m = 0;
                if (r > 0 && heights[i-nc] < heights[i] && path_len[i-nc] > m) m = path_len[i-nc];
                if (r + 1 < nr && heights[i+nc] < heights[i] && path_len[i+nc] > m)
                    m = path_len[i+nc];
                if (c > 0 && heights[i-1] < heights[i] && path_len[i-1] > m) m = path_len[i-1];
                if (c + 1 < nc && heights[i+1] < heights[i] && path_len[i+1] > m)
                    m = path_len[i+1];
                if (m + 1 > path_len[i]) begin
                    path_len[i] = m + 1;
                    changed = 1;
                end
            end
        end
        for (i = 0; i < total; i++) if (path_len[i] > best) best = path_len[i];
        return best[LONGEST_BITS-1:0];
    endfunction

    always @(posedge i_clk) begin
        int total;
        logic [LONGEST_BITS-1:0] want;
        if (!i_rst_n) begin
            rows_reg = 1;
            cols_reg = 1;
            loaded = 0;
            fails = 0;
            longest_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_ROWS) rows_reg = i_cfg_value;
                else if (i_cfg_index == REG_COLS) cols_reg = i_cfg_value;
            end
            if (i_res_valid && i_res_ready) begin
                if (longest_q.size() == 0) begin
                    $error("unexpected result transaction: longest=%0d", i_longest);
                    fails++;
                end else begin
                    want = longest_q.pop_front();
                    if (i_longest !== want) begin
                        $error("longest: expected %0d, actual %0d", want, i_longest);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                total = clamp_size(rows_reg, DEF_MAX_ROWS) * clamp_size(cols_reg, DEF_MAX_COLS);
                if (loaded < total) begin
                    heights[loaded] = i_height;
                    loaded++;
                end
                if (i_last) begin
                    longest_q.push_back(longest_descent(clamp_size(rows_reg, DEF_MAX_ROWS),
                                                        clamp_size(cols_reg, DEF_MAX_COLS)));
                    loaded = 0;
                end
            end
        end
        o_fails <= fails;
        o_pending <= longest_q.size();
    end
endmodule

// ===== dv/grid_longest_descent_path_test.sv =====
// Testbench top for the grid longest descending path block: stimulus and verdict.
module grid_longest_descent_path_test;
    timeunit 1ns;
    timeprecision 1ps;
    import gld_pkg::*;

    logic                      clk = 0;
    logic                      rst_n = 0;
    logic                      in_valid = 0;
    logic                      in_ready;
    logic [IN_HEIGHT_BITS-1:0] height = '0;
    logic                      last = 0;
    logic                      res_valid;
    logic                      res_ready = 0;
    logic [LONGEST_BITS-1:0]   longest;
    logic                      cfg_valid = 0;
    logic                      cfg_ready;
    logic [CFG_IDX_BITS-1:0]   cfg_index = REG_ROWS;
    logic [CFG_REG_BITS-1:0]   cfg_value = '0;
    int                        fails, pending;

    int  cur_rows = 1, cur_cols = 1, written_hi = 0, stall_cnt = 0, random_items = 0;
    bit  calm = 0;

    always #2 clk = ~clk;

    grid_longest_descent_path dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready), .i_height(height), .i_last(last),
        .o_valid(res_valid), .i_ready(res_ready), .o_longest(longest),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_value(cfg_value)
    );

    gld_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_height(height), .i_last(last),
        .i_res_valid(res_valid), .i_res_ready(res_ready), .i_longest(longest),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_value(cfg_value),
        .o_fails(fails), .o_pending(pending)
    );

    // result side back-pressure
    always @(posedge clk) begin
        int w;
        if (!rst_n) begin
            res_ready <= 0;
            stall_cnt <= 0;
        end else if (stall_cnt != 0) begin
            stall_cnt <= stall_cnt - 1;
            if (stall_cnt == 1) res_ready <= 1;
        end else if (res_valid && res_ready) begin
            w = calm ? 0 : $urandom_range(0, 7);
            if (w != 0) begin
                res_ready <= 0;
                stall_cnt <= w;
            end
        end else if (!res_ready) begin
            res_ready <= 1;
        end
    end

    function automatic int clamp_size(int v);
        if (v == 0) return 1;
        if (v > 64) return 64;
        return v;
    endfunction

    task automatic send(logic [IN_HEIGHT_BITS-1:0] h, logic lst);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        height <= h;
        last <= lst;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, int v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_value <= v[CFG_REG_BITS-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic set_size(int r, int c);
        drain();
        cfg_write(REG_ROWS, r);
        cfg_write(REG_COLS, c);
        cur_rows = clamp_size(r);
        cur_cols = clamp_size(c);
    endtask

    function automatic logic [IN_HEIGHT_BITS-1:0] cell_height(int pattern, int i);
        int r, c;
        r = i / cur_cols;
        c = i % cur_cols;
        case (pattern)
            0: return IN_HEIGHT_BITS'($urandom);
            1: return IN_HEIGHT_BITS'($urandom_range(0, 3));
            2: return IN_HEIGHT_BITS'(i);
            3: return 16'hA5A5;
            4: return IN_HEIGHT_BITS'((r % 2 == 0) ? r * cur_cols + c
                                                   : r * cur_cols + cur_cols - 1 - c);
            5: return IN_HEIGHT_BITS'(32'hFFFF - i);
            default: return (i % 2) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    // delta > 0: surplus cells after the grid; delta < 0: last arrives early
    task automatic grid(int pattern, int delta);
        int total, n;
        total = cur_rows * cur_cols;
        n = total + delta;
        for (int i = 0; i < n; i++) send(cell_height(pattern, i), i == n - 1);
        if ((n < total ? n : total) > written_hi) written_hi = (n < total ? n : total);
    endtask

    initial begin
        int total, kind;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        set_size(0, 0);
        grid(6, 0);
        grid(5, 0);
        set_size(2, 3);
        grid(0, 0);
        grid(1, 3);
        grid(2, -2);
        set_size(4, 4);
        grid(4, 0);
        grid(3, 0);
        calm = 1;
        set_size(127, 2);
        grid(1, 0);
        set_size(1, 64);
        grid(2, 0);
        calm = 0;
        set_size(64, 1);
        grid(5, 0);
        set_size(8, 8);
        grid(4, 0);
        grid(6, -20);

        set_size(3, 3);
        while (random_items < 600) begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 5))
                    0: set_size($urandom_range(65, 127), $urandom_range(0, 2));
                    1: set_size($urandom_range(0, 2), $urandom_range(65, 127));
                    2: set_size($urandom_range(1, 12), $urandom_range(1, 12));
                    default: set_size($urandom_range(1, 6), $urandom_range(1, 6));
                endcase
            end
            total = cur_rows * cur_cols;
            kind = $urandom_range(0, 9);
            if (kind == 8) begin
                kind = $urandom_range(1, 3);
                random_items += total + kind;
                grid($urandom_range(0, 6), kind);
            end else if (kind == 9 && total > 1 && written_hi >= total) begin
                kind = $urandom_range(1, total - 1);
                random_items += total - kind;
                grid($urandom_range(0, 6), -kind);
            end else begin
                random_items += total;
                grid($urandom_range(0, 6), 0);
            end
        end

        drain();
        if (fails == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/gld_pkg.sv
hdl/gld_mem.sv
hdl/grid_longest_descent_path.sv
dv/gld_checker.sv
dv/grid_longest_descent_path_test.sv
